// File: hdl/sfsr_pkg.sv
// Shared types and constants of the serial frame sender with resend.
// Used by sfsr_ctrl, sfsr_dp and the top level; depends on nothing.
`default_nettype none
package sfsr_pkg;

    localparam int ID_W       = 16;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 4;
    localparam int MOD_STEPS  = 2;
    localparam int MOD_STEP_W = 2;
    localparam int HDR_IDX_W  = 2;

    localparam logic [HDR_IDX_W-1:0] HDR_LAST = 2'd3;

    localparam logic [BYTE_W-1:0] SYNC_A = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_B = 8'hAA;

    localparam logic REQ_PAYLOAD = 1'b0;
    localparam logic REQ_RESEND  = 1'b1;

    typedef enum logic [2:0] {
        EM_SYNC_A,
        EM_SYNC_B,
        EM_ID_HI,
        EM_ID_LO,
        EM_DATA,
        EM_STORED,
        EM_ERROR,
        EM_CSUM
    } t_emit_sel;

    typedef struct packed {
        logic      load_in;
        logic      mod_step;
        logic      len_read;
        logic      mem_read;
        logic      emit;
        t_emit_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic in_packet;
        logic last;
        logic full;
        logic src_valid;
        logic stored_last;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

// File: hdl/sfsr_ctrl.sv
// Controller state machine of the frame sender: sequences header, payload,
// checksum, resend walk and error transactions. Depends on sfsr_pkg.
`default_nettype none
module sfsr_ctrl import sfsr_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_req_type,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_CHK,
        ST_HDR,
        ST_BYTE,
        ST_RD,
        ST_RDAT,
        ST_CSUM,
        ST_ERR
    } t_state;

    t_state                r_state,   n_state;
    logic [HDR_IDX_W-1:0]  r_hdr_idx, n_hdr_idx;
    logic [MOD_STEP_W-1:0] r_step,    n_step;
    logic                  r_resend,  n_resend;

    always_comb begin
        n_state    = r_state;
        n_hdr_idx  = r_hdr_idx;
        n_step     = r_step;
        n_resend   = r_resend;
        o_in_ready = 1'b0;
        o_cmd      = '{load_in: 1'b0, mod_step: 1'b0, len_read: 1'b0,
                       mem_read: 1'b0, emit: 1'b0, sel: EM_ERROR};
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_hdr_idx     = '0;
                    n_step        = '0;
                    if (i_req_type == REQ_RESEND) begin
                        n_resend = 1'b1;
                        n_state  = i_status.in_packet ? ST_ERR : ST_MOD;
                    end else begin
                        n_resend = 1'b0;
                        n_state  = i_status.in_packet ? ST_BYTE : ST_HDR;
                    end
                end
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == MOD_STEP_W'(MOD_STEPS - 1)) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_status.src_valid) begin
                    o_cmd.len_read = 1'b1;
                    n_state        = ST_HDR;
                end else begin
                    n_state = ST_ERR;
                end
            end
            ST_HDR: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    case (r_hdr_idx)
                        2'd0:    o_cmd.sel = EM_SYNC_A;
                        2'd1:    o_cmd.sel = EM_SYNC_B;
                        2'd2:    o_cmd.sel = EM_ID_HI;
                        default: o_cmd.sel = EM_ID_LO;
                    endcase
                    n_hdr_idx = r_hdr_idx + 1'b1;
                    if (r_hdr_idx == HDR_LAST) begin
                        n_state = r_resend ? ST_RD : ST_BYTE;
                    end
                end
            end
            ST_BYTE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = i_status.full ? EM_ERROR : EM_DATA;
                    n_state    = i_status.last ? ST_CSUM : ST_IDLE;
                end
            end
            ST_RD: begin
                o_cmd.mem_read = 1'b1;
                n_state        = ST_RDAT;
            end
            ST_RDAT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = EM_STORED;
                    n_state    = i_status.stored_last ? ST_CSUM : ST_RD;
                end
            end
            ST_CSUM: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = EM_CSUM;
                    n_state    = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = EM_ERROR;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_hdr_idx <= '0;
            r_step    <= '0;
            r_resend  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hdr_idx <= n_hdr_idx;
            r_step    <= n_step;
            r_resend  <= n_resend;
        end
    end

endmodule
`default_nettype wire

// File: hdl/sfsr_dp.sv
// Datapath of the frame sender: id and slot counters, checksum, payload and
// length memories, slot reduction unit and output register. Uses sfsr_pkg.
`default_nettype none
module sfsr_dp import sfsr_pkg::*; #(
    parameter int SLOTS       = 16,
    parameter int MAX_PAYLOAD = 15
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  wire               i_req_type,
    input  wire  [BYTE_W-1:0] i_data_byte,
    input  wire               i_last_byte,
    input  wire  [ID_W-1:0]   i_resend_id,
    input  wire               i_out_ready,
    output t_dp_status        o_status,
    output logic              o_out_valid,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_frame_end,
    output logic              o_error
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEPTH  = SLOTS * MAX_PAYLOAD;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // reciprocal of SLOTS, exact for every id of ID_W bits
    localparam int RECIP_SH = ID_W + SLOT_W;
    localparam int RECIP_W  = ID_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SH) + SLOTS - 1) / SLOTS);

    // latched request
    logic              r_req;
    logic [BYTE_W-1:0] r_data;
    logic              r_last;
    logic [ID_W-1:0]   r_rid;

    // frame state
    logic [ID_W-1:0]   r_next_id;
    logic [SLOT_W-1:0] r_dst_slot;
    logic [SLOT_W-1:0] r_src_slot;
    logic [ID_W-1:0]   r_quot;
    logic              r_in_packet;
    logic [BYTE_W-1:0] r_sum;
    logic [CNT_W-1:0]  r_count;
    logic [SLOTS-1:0]  r_slot_valid;

    // memories
    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_mem_q;
    logic [CNT_W-1:0]  r_len_mem [SLOTS];
    logic [CNT_W-1:0]  r_len_q;

    // output register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_end;
    logic              r_out_err;

    logic [ID_W+RECIP_W-1:0] quot_prod;
    logic [ID_W-1:0]         quot_back;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic              mem_we;
    logic [BYTE_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] emit_byte;
    logic [BYTE_W-1:0] id_hi;
    logic [BYTE_W-1:0] id_lo;
    logic              out_free;

    assign id_hi    = r_next_id[ID_W-1 -: BYTE_W];
    assign id_lo    = r_next_id[BYTE_W-1:0];
    assign out_free = !r_out_valid || i_out_ready;
    assign src_addr = ADDR_W'(r_src_slot * MAX_PAYLOAD) + ADDR_W'(r_count);
    assign dst_addr = ADDR_W'(r_dst_slot * MAX_PAYLOAD) + ADDR_W'(r_count);

    // slot reduction: first step forms the quotient, second the remainder
    assign quot_prod = {{RECIP_W{1'b0}}, r_rid} * {{ID_W{1'b0}}, RECIP};
    assign quot_back = ID_W'(r_quot * SLOTS);

    always_comb begin
        mem_we    = i_cmd.emit && (i_cmd.sel == EM_STORED ||
                    (i_cmd.sel == EM_DATA));
        mem_wdata = (i_cmd.sel == EM_STORED) ? r_mem_q : r_data;
    end

    always_comb begin
        case (i_cmd.sel)
            EM_SYNC_A: emit_byte = SYNC_A;
            EM_SYNC_B: emit_byte = SYNC_B;
            EM_ID_HI:  emit_byte = id_hi;
            EM_ID_LO:  emit_byte = id_lo;
            EM_DATA:   emit_byte = r_data;
            EM_STORED: emit_byte = r_mem_q;
            EM_CSUM:   emit_byte = ~r_sum;
            default:   emit_byte = '0;
        endcase
    end

    always_comb begin
        o_status.in_packet   = r_in_packet;
        o_status.last        = r_last;
        o_status.full        = (r_count == CNT_W'(MAX_PAYLOAD));
        o_status.src_valid   = r_slot_valid[r_src_slot];
        o_status.stored_last = (({1'b0, r_count} + 1'b1) == {1'b0, r_len_q});
        o_status.out_free    = out_free;
    end

    // payload and length memories
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[dst_addr] <= mem_wdata;
        end
        if (i_cmd.mem_read) begin
            r_mem_q <= r_mem[src_addr];
        end
        if (i_cmd.emit && i_cmd.sel == EM_CSUM) begin
            r_len_mem[r_dst_slot] <= r_count;
        end
        if (i_cmd.len_read) begin
            r_len_q <= r_len_mem[r_src_slot];
        end
    end

    // request latch, reduction unit and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req      <= i_req_type;
            r_data     <= i_data_byte;
            r_last     <= i_last_byte;
            r_rid      <= i_resend_id;
            r_src_slot <= '0;
        end else if (i_cmd.mod_step) begin
            r_quot     <= ID_W'(quot_prod >> RECIP_SH);
            r_src_slot <= SLOT_W'(r_rid - quot_back);
        end
        if (i_cmd.emit) begin
            r_out_byte <= emit_byte;
            r_out_end  <= (i_cmd.sel == EM_CSUM);
            r_out_err  <= (i_cmd.sel == EM_ERROR);
        end
    end

    // frame state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_id    <= '0;
            r_dst_slot   <= '0;
            r_in_packet  <= 1'b0;
            r_sum        <= '0;
            r_count      <= '0;
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.emit) begin
                case (i_cmd.sel)
                    EM_ID_LO: begin
                        r_sum   <= id_hi + id_lo;
                        r_count <= '0;
                        if (r_req == REQ_PAYLOAD) begin
                            r_in_packet <= 1'b1;
                        end
                    end
                    EM_DATA, EM_STORED: begin
                        r_sum   <= r_sum + mem_wdata;
                        r_count <= r_count + 1'b1;
                    end
                    EM_CSUM: begin
                        r_slot_valid[r_dst_slot] <= 1'b1;
                        r_next_id   <= r_next_id + 1'b1;
                        r_in_packet <= 1'b0;
                        r_sum       <= '0;
                        r_count     <= '0;
                        if (r_next_id == {ID_W{1'b1}} ||
                            r_dst_slot == SLOT_W'(SLOTS - 1)) begin
                            r_dst_slot <= '0;
                        end else begin
                            r_dst_slot <= r_dst_slot + 1'b1;
                        end
                    end
                    default: begin
                        r_sum <= r_sum;
                    end
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_frame_end = r_out_end;
    assign o_error     = r_out_err;

endmodule
`default_nettype wire

// File: hdl/serial_frame_sender_with_resend_unit.sv
// Top level of the serial frame sender with resend buffer.
// Joins the controller (sfsr_ctrl) and the datapath (sfsr_dp); uses sfsr_pkg.
`default_nettype none
// Frames payload bytes into serial frames: 0x55, 0xAA, the 16-bit sequence id
// (high byte first), the payload, and a checksum that is the inverse of the
// 8-bit sum of the id bytes and the payload. Each payload of up to MAX_PAYLOAD
// bytes is kept in ring slot (id mod SLOTS); a resend transaction replays a
// stored slot as a new frame under the next id and copies it to that id's
// slot. Bytes past MAX_PAYLOAD, a resend inside an open packet and a resend
// of an empty slot each give one result with error set and a zero byte.
// The block takes one input transaction at a time and has no clearing pass
// after reset: slot emptiness is kept in one valid flop per slot.
// A payload byte also sends the header on a packet's first byte and the
// checksum on its last byte; a resend sends the header, the stored payload
// and the checksum. A resend reduces the id to a slot by reciprocal
// multiplication (quotient, then remainder), and walks the stored payload
// one byte at a time, each through the registered read of the single
// payload memory. Each stall of the output holds the sequence.
module serial_frame_sender_with_resend_unit import sfsr_pkg::*; #(
    parameter int SLOTS       = 16,
    parameter int MAX_PAYLOAD = 15
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    // request channel
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire               i_req_type,
    input  wire  [BYTE_W-1:0] i_data_byte,
    input  wire               i_last_byte,
    input  wire  [ID_W-1:0]   i_resend_id,
    // serial byte channel
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_frame_end,
    output logic              o_error
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequence each transaction: header, payload or stored walk, checksum, or error byte.
    sfsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Hold the id, sum, memories and the output register.
    sfsr_dp #(
        .SLOTS       (SLOTS),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req_type  (i_req_type),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_resend_id (i_resend_id),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end),
        .o_error     (o_error)
    );

endmodule
`default_nettype wire

// File: bench/tb_serial_frame_sender_with_resend_unit.sv
// Self-checking bench for serial_frame_sender_with_resend_unit: directed table,
// then two rounds of random packets and resends with a full drain between them.
// Depends on sfsr_pkg and the RTL only.
`timescale 1ns / 1ps
module tb_serial_frame_sender_with_resend_unit;
    import sfsr_pkg::*;

    localparam int SLOTS        = 16;
    localparam int MAX_PAYLOAD  = 15;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 2;
    // Settle past the longest resend once every owed byte is in.
    localparam int TAIL_CYCLES  = 48;
    // Cycles without any transaction on either channel before giving up.
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_HEAD  = 200;
    localparam int RANDOM_TAIL  = 190;

    // One byte on the serial channel.
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              frame_end;
        logic              error;
    } line_byte_t;

    // One row of the directed table; reject means the single error byte is typed in.
    typedef struct packed {
        logic              req;
        logic [BYTE_W-1:0] data;
        logic              last_flag;
        logic [ID_W-1:0]   rid;
        logic              reject;
    } stim_row_t;

    localparam line_byte_t REJECT_BYTE = '{8'h00, 1'b0, 1'b1};

    localparam int N_DIRECTED = 25;
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // resend right after reset: every slot is empty
        '{REQ_RESEND,  8'h00, 1'b0, 16'hFFFF, 1'b1},
        // open frame 0 with the smallest byte
        '{REQ_PAYLOAD, 8'h00, 1'b0, 16'h0000, 1'b0},
        // resend inside an open packet
        '{REQ_RESEND,  8'hFF, 1'b1, 16'h0000, 1'b1},
        // fill frame 0 up to a full payload
        '{REQ_PAYLOAD, 8'hFF, 1'b0, 16'hFFFF, 1'b0},
        '{REQ_PAYLOAD, 8'h80, 1'b0, 16'h0000, 1'b0},
        '{REQ_PAYLOAD, 8'h01, 1'b0, 16'h0000, 1'b0},
        '{REQ_PAYLOAD, 8'h7F, 1'b0, 16'h0000, 1'b0},
        '{REQ_PAYLOAD, 8'hAA, 1'b0, 16'h0000, 1'b0},
        '{REQ_PAYLOAD, 8'h55, 1'b0, 16'h0000, 1'b0},
        '{REQ_PAYLOAD, 8'hFE, 1'b0, 16'h0000, 1'b0},
        '{REQ_PAYLOAD, 8'h02, 1'b0, 16'h0000, 1'b0},
        '{REQ_PAYLOAD, 8'hC3, 1'b0, 16'h0000, 1'b0},
        '{REQ_PAYLOAD, 8'h3C, 1'b0, 16'h0000, 1'b0},
        '{REQ_PAYLOAD, 8'h10, 1'b0, 16'h0000, 1'b0},
        '{REQ_PAYLOAD, 8'hEF, 1'b0, 16'h0000, 1'b0},
        '{REQ_PAYLOAD, 8'hFF, 1'b0, 16'h0000, 1'b0},
        '{REQ_PAYLOAD, 8'h5A, 1'b0, 16'h0000, 1'b0},
        // payload full: drop the byte
        '{REQ_PAYLOAD, 8'hA5, 1'b0, 16'h0000, 1'b1},
        // dropped byte marked last: error, then the checksum
        '{REQ_PAYLOAD, 8'h77, 1'b1, 16'h0000, 1'b0},
        // replay the full slot 0 as frame 1
        '{REQ_RESEND,  8'h00, 1'b0, 16'h0010, 1'b0},
        // single-byte frame 2 with the largest byte
        '{REQ_PAYLOAD, 8'hFF, 1'b1, 16'h0000, 1'b0},
        // replay the single-byte slot 2
        '{REQ_RESEND,  8'h00, 1'b1, 16'h0002, 1'b0},
        // slot 1 holds id 1, not 0xFFF1: replayed all the same
        '{REQ_RESEND,  8'hFF, 1'b0, 16'hFFF1, 1'b0},
        // slot 5 never written
        '{REQ_RESEND,  8'h00, 1'b0, 16'h0005, 1'b1},
        '{REQ_PAYLOAD, 8'h00, 1'b1, 16'hFFFF, 1'b0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_req_type = 1'b0;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              i_last_byte = 1'b0;
    logic [ID_W-1:0]   i_resend_id = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_frame_end;
    logic              o_error;

    serial_frame_sender_with_resend_unit #(
        .SLOTS      (SLOTS),
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_req_type (i_req_type),
        .i_data_byte(i_data_byte),
        .i_last_byte(i_last_byte),
        .i_resend_id(i_resend_id),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_byte (o_out_byte),
        .o_frame_end(o_frame_end),
        .o_error    (o_error)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Framer state as seen by the bench
    // ---------------------------------------------------------------------
    logic [ID_W-1:0]   cur_id = '0;
    logic              frame_open = 1'b0;
    logic [BYTE_W-1:0] csum_acc = '0;
    logic [CNT_W-1:0]  byte_cnt = '0;
    logic [BYTE_W-1:0] slot_bytes [SLOTS][MAX_PAYLOAD];
    logic [CNT_W-1:0]  slot_fill [SLOTS] = '{default: '0};

    line_byte_t frame_bytes [$];    // bytes caused by the latest request
    line_byte_t awaited_bytes [$];  // bytes still owed by the block
    line_byte_t head_byte;

    int  items_sent    = 0;
    int  frames_closed = 0;
    int  replays       = 0;
    int  rejects       = 0;
    int  mismatches    = 0;
    int  idle_cycles   = 0;
    int  sink_hold     = 0;
    bit  id_wrapped    = 1'b0;
    // Both sides run without gaps while set.
    bit  no_idle       = 1'b0;

    function automatic void push_byte(input logic [BYTE_W-1:0] value, input logic frame_end,
                                      input logic error);
        frame_bytes.push_back('{value, frame_end, error});
    endfunction

    // Emit sync and id bytes; return the id part of the checksum.
    function automatic logic [BYTE_W-1:0] push_header();
        push_byte(SYNC_A, 1'b0, 1'b0);
        push_byte(SYNC_B, 1'b0, 1'b0);
        push_byte(cur_id[15:8], 1'b0, 1'b0);
        push_byte(cur_id[7:0], 1'b0, 1'b0);
        return cur_id[15:8] + cur_id[7:0];
    endfunction

    function automatic void advance_id();
        if (cur_id == '1)
            id_wrapped = 1'b1;
        cur_id++;
        frames_closed++;
    endfunction

    // Compute the serial bytes one request causes and update the framer state.
    function automatic void predict_serial_bytes(input logic req, input logic [BYTE_W-1:0] data,
                                                 input logic last_flag,
                                                 input logic [ID_W-1:0] rid);
        int unsigned       dst;
        int unsigned       src;
        int unsigned       len;
        int                k;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] copy [MAX_PAYLOAD];

        frame_bytes.delete();
        dst = cur_id % SLOTS;
        if (req == REQ_PAYLOAD) begin
            if (!frame_open) begin
                csum_acc   = push_header();
                byte_cnt   = '0;
                frame_open = 1'b1;
            end
            if (byte_cnt < MAX_PAYLOAD) begin
                slot_bytes[dst][byte_cnt] = data;
                csum_acc += data;
                byte_cnt++;
                push_byte(data, 1'b0, 1'b0);
            end else begin
                push_byte('0, 1'b0, 1'b1);
                rejects++;
            end
            if (last_flag) begin
                push_byte(~csum_acc, 1'b1, 1'b0);
                slot_fill[dst] = byte_cnt;
                advance_id();
                frame_open = 1'b0;
                csum_acc   = '0;
                byte_cnt   = '0;
            end
            return;
        end

        src = rid % SLOTS;
        len = slot_fill[src];
        if (frame_open || len == 0) begin
            push_byte('0, 1'b0, 1'b1);
            rejects++;
            return;
        end
        // Take a copy first: source and destination slot may be the same.
        for (k = 0; k < len; k++)
            copy[k] = slot_bytes[src][k];
        sum = push_header();
        for (k = 0; k < len; k++) begin
            sum += copy[k];
            push_byte(copy[k], 1'b0, 1'b0);
        end
        push_byte(~sum, 1'b1, 1'b0);
        for (k = 0; k < len; k++)
            slot_bytes[dst][k] = copy[k];
        slot_fill[dst] = CNT_W'(len);
        replays++;
        advance_id();
    endfunction

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one request after gap idle cycles, hold it until the block takes
    // it, then queue the bytes it owes. Call at a rising edge.
    task automatic send_request(input logic req, input logic [BYTE_W-1:0] data,
                                input logic last_flag, input logic [ID_W-1:0] rid,
                                input int gap, input logic reject);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_data_byte <= data;
        i_last_byte <= last_flag;
        i_resend_id <= rid;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        predict_serial_bytes(req, data, last_flag, rid);
        if (reject)
            awaited_bytes.push_back(REJECT_BYTE);
        else
            foreach (frame_bytes[k])
                awaited_bytes.push_back(frame_bytes[k]);
    endtask

    // Drop valid and wait until the block has delivered every owed byte.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        wait (awaited_bytes.size() == 0);
        @(posedge i_clk);
    endtask

    // Random packets of random content, resends aimed mostly at recent slots,
    // and some noise: overlong packets, resends inside a packet, random ids.
    task automatic run_random_traffic(input int item_budget);
        int              issued;
        int              roll;
        int              len;
        int              k;
        logic [ID_W-1:0] rid;

        issued = 0;
        while (issued < item_budget) begin
            if ($urandom_range(0, 49) == 0)
                no_idle = !no_idle;
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_PAYLOAD + 1, MAX_PAYLOAD + 3)
                                                  : $urandom_range(1, MAX_PAYLOAD);
                for (k = 0; k < len; k++) begin
                    if (k > 0 && $urandom_range(0, 19) == 0) begin
                        send_request(REQ_RESEND, 8'($urandom), 1'($urandom), 16'($urandom),
                                     pick_gap(), 1'b0);
                        issued++;
                    end
                    send_request(REQ_PAYLOAD, 8'($urandom), 1'(k == len - 1), 16'($urandom),
                                 pick_gap(), 1'b0);
                    issued++;
                end
            end else if (roll < 85) begin
                // Aim at one of the last 15 slots, or at the destination slot itself,
                // under random upper id bits.
                rid      = 16'($urandom);
                rid[3:0] = cur_id[3:0] - 4'($urandom_range(0, SLOTS));
                send_request(REQ_RESEND, 8'($urandom), 1'($urandom), rid, pick_gap(), 1'b0);
                issued++;
            end else begin
                send_request(REQ_RESEND, 8'($urandom), 1'($urandom), 16'($urandom),
                             pick_gap(), 1'b0);
                issued++;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Output side: random back-pressure and byte checking
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || no_idle) begin
            i_out_ready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            sink_hold = pick_gap();
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare every accepted byte against the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_bytes.size() == 0) begin
                $error("out_byte: unexpected transaction, got 0x%02h (frame_end %0b, error %0b)",
                       o_out_byte, o_frame_end, o_error);
                mismatches++;
            end else begin
                head_byte = awaited_bytes.pop_front();
                if (o_out_byte !== head_byte.value) begin
                    $error("out_byte: expected 0x%02h, got 0x%02h", head_byte.value, o_out_byte);
                    mismatches++;
                end
                if (o_frame_end !== head_byte.frame_end) begin
                    $error("frame_end: expected %0b, got %0b", head_byte.frame_end, o_frame_end);
                    mismatches++;
                end
                if (o_error !== head_byte.error) begin
                    $error("error: expected %0b, got %0b", head_byte.error, o_error);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: restart the count on any transaction, end the run when the block goes quiet.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d bytes still owed",
                     idle_cycles, awaited_bytes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table.
        for (int r = 0; r < N_DIRECTED; r++)
            send_request(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].data,
                         DIRECTED_ROWS[r].last_flag, DIRECTED_ROWS[r].rid,
                         pick_gap(), DIRECTED_ROWS[r].reject);
        // Let the table fully drain before random traffic starts.
        hold_until_drained();

        run_random_traffic(RANDOM_HEAD);
        hold_until_drained();

        run_random_traffic(RANDOM_TAIL);

        i_in_valid <= 1'b0;
        wait (awaited_bytes.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests: %0d frames (%0d replays), %0d rejects or drops.",
                 items_sent, frames_closed, replays, rejects);
        $display("Sequence id wrapped: %s; mismatches: %0d.", id_wrapped ? "yes" : "no",
                 mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
